>>> rtl/cbtt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbtt_pkg
// shared types, sizes and helpers of the complete binary tree table
// ----------------------------------------------------------------------------
package cbtt_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = 7;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int KEY_W    = 32;
    localparam int OP_W     = 3;
    localparam int HGT_W    = 4;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 48;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_SEARCH = 3'd2,
        OP_IN     = 3'd3,
        OP_PRE    = 3'd4,
        OP_POST   = 3'd5,
        OP_LEVEL  = 3'd6
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LEVEL,
        ST_WALK,
        ST_REPLY
    } state_t;

    // where the walker stands at a node
    typedef enum logic [1:0] {
        PH_ENTER,
        PH_LEFT_DONE,
        PH_RIGHT_DONE
    } phase_t;

    // floor(log2(n)), all ones when n is zero
    function automatic logic [HGT_W-1:0] height_code(input logic [CNT_W-1:0] n);
        logic [HGT_W-1:0] h;
        h = '1;
        for (int i = 0; i < CNT_W; i++)
        begin
            if (n[i])
            begin
                h = HGT_W'(i);
            end
        end
        return h;
    endfunction

endpackage
`default_nettype wire

>>> rtl/complete_binary_tree_table_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// complete_binary_tree_table_top
// level-order complete binary tree of signed values with insert, delete,
// search and four traversals, run by a small sequencer over one slot memory
// ----------------------------------------------------------------------------
// One item at a time: s_tready is high only while the sequencer is idle. Insert
// and any reply-only request pass through the reply state only. Search and delete read one slot
// per cycle through the single memory read port; the delete move is done in the
// last scan cycle. Level order streams one entry per cycle while the output is
// not stalled. Inorder, preorder and postorder run a stackless walker that takes
// one tree step per cycle, at most three steps per node; output stalls hold the
// steps that emit, and the result register lets the next step run while a beat
// waits. The slot memory needs no clearing after reset.
module complete_binary_tree_table_top
    import cbtt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // opcode[2:0], key_value[34:3], zero pad[39:35]
    input  wire logic [IN_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // element[31:0], found[32], full_res[33], empty_res[34], height_now[38:35],
    // count_now[45:39], zero pad[47:46]
    output logic [OUT_W-1:0]      m_tdata,
    output logic                  m_tlast
);

    state_t               state_reg, state_next;
    phase_t               phase_reg, phase_next;
    opcode_t              op_reg, op_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     node_reg, node_next;
    logic [CNT_W-1:0]     emit_cnt_reg, emit_cnt_next;
    logic                 hit_reg, hit_next;
    logic [IDX_W-1:0]     target_reg, target_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic                 rep_found_reg, rep_found_next;
    logic                 rep_full_reg, rep_full_next;
    logic                 rep_empty_reg, rep_empty_next;

    logic                 out_valid_reg;
    logic [KEY_W-1:0]     out_elem_reg;
    logic                 out_found_reg, out_full_reg, out_empty_reg, out_last_reg;
    logic [HGT_W-1:0]     out_height_reg;
    logic [CNT_W-1:0]     out_count_reg;

    logic [KEY_W-1:0]     mem [CAPACITY];
    logic [KEY_W-1:0]     rd_data_reg;
    logic [IDX_W-1:0]     rd_addr;
    logic [CNT_W-1:0]     node_m1;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [KEY_W-1:0]     mem_wdata;

    logic                 emit;
    logic [KEY_W-1:0]     e_elem;
    logic                 e_found, e_full, e_empty, e_last;

    logic                 out_free;
    logic                 in_fire;
    opcode_t              op_in;
    logic [KEY_W-1:0]     key_in;
    logic                 scan_match, scan_done, scan_hit;
    logic [IDX_W-1:0]     scan_target;
    logic [IDX_W-1:0]     node_idx;
    logic                 walk_emit, walk_ok, walk_last, level_last;
    logic [CNT_W+1:0]     child_l, child_r, cnt_wide;

    function automatic logic [IDX_W-1:0] node_m1_cur(input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] d;
        d = n - CNT_W'(1);
        return d[IDX_W-1:0];
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign op_in    = opcode_t'(s_tdata[OP_W-1:0]);
    assign key_in   = s_tdata[OP_W+KEY_W-1:OP_W];
    assign out_free = !out_valid_reg || m_tready;

    assign node_idx    = node_m1_cur(node_reg);
    assign scan_match  = (rd_data_reg == key_reg);
    assign scan_done   = (node_reg == cnt_reg);
    assign scan_hit    = hit_reg || scan_match;
    assign scan_target = scan_match ? node_idx : target_reg;

    assign child_l  = {1'b0, node_reg, 1'b0};
    assign child_r  = {1'b0, node_reg, 1'b1};
    assign cnt_wide = {2'b00, cnt_reg};

    assign walk_emit  = ((phase_reg == PH_ENTER)      && (op_reg == OP_PRE))
                     || ((phase_reg == PH_LEFT_DONE)  && (op_reg == OP_IN))
                     || ((phase_reg == PH_RIGHT_DONE) && (op_reg == OP_POST));
    assign walk_ok    = !walk_emit || out_free;
    assign walk_last  = ((emit_cnt_reg + CNT_W'(1)) == cnt_reg);
    assign level_last = (node_reg == cnt_reg);

    // the memory is addressed from the next node, so its data is ready on arrival
    assign node_m1 = node_next - CNT_W'(1);
    assign rd_addr = node_m1[IDX_W-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (op_in)
                        OP_DELETE, OP_SEARCH:
                            state_next = (cnt_reg == '0) ? ST_REPLY : ST_SCAN;
                        OP_IN, OP_PRE, OP_POST:
                            state_next = (cnt_reg == '0) ? ST_REPLY : ST_WALK;
                        OP_LEVEL:
                            state_next = (cnt_reg == '0) ? ST_REPLY : ST_LEVEL;
                        default:
                            state_next = ST_REPLY;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_REPLY;
                end
            end
            ST_LEVEL:
            begin
                if (out_free && level_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WALK:
            begin
                if (walk_ok)
                begin
                    if (walk_emit && walk_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if ((phase_reg == PH_RIGHT_DONE) && (node_reg == CNT_W'(1)))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_REPLY:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        phase_next     = phase_reg;
        op_next        = op_reg;
        cnt_next       = cnt_reg;
        node_next      = node_reg;
        emit_cnt_next  = emit_cnt_reg;
        hit_next       = hit_reg;
        target_next    = target_reg;
        key_next       = key_reg;
        rep_found_next = rep_found_reg;
        rep_full_next  = rep_full_reg;
        rep_empty_next = rep_empty_reg;
        mem_we         = 1'b0;
        mem_waddr      = cnt_reg[IDX_W-1:0];
        mem_wdata      = key_in;
        emit           = 1'b0;
        e_elem         = '0;
        e_found        = 1'b0;
        e_full         = 1'b0;
        e_empty        = 1'b0;
        e_last         = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    op_next        = op_in;
                    key_next       = key_in;
                    node_next      = CNT_W'(1);
                    phase_next     = PH_ENTER;
                    emit_cnt_next  = '0;
                    hit_next       = 1'b0;
                    rep_found_next = 1'b0;
                    rep_full_next  = 1'b0;
                    rep_empty_next = 1'b0;
                    case (op_in)
                        OP_INSERT:
                        begin
                            if (cnt_reg >= CNT_W'(CAPACITY))
                            begin
                                rep_full_next = 1'b1;
                            end
                            else
                            begin
                                mem_we   = 1'b1;
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                        end
                        OP_IN, OP_PRE, OP_POST, OP_LEVEL:
                            rep_empty_next = (cnt_reg == '0);
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                hit_next    = scan_hit;
                target_next = scan_target;
                if (scan_done)
                begin
                    rep_found_next = scan_hit;
                    // read data is the last entry here, move it over the victim
                    if ((op_reg == OP_DELETE) && scan_hit)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = scan_target;
                        mem_wdata = rd_data_reg;
                        cnt_next  = cnt_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    node_next = node_reg + CNT_W'(1);
                end
            end
            ST_LEVEL:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    e_elem    = rd_data_reg;
                    e_last    = level_last;
                    node_next = node_reg + CNT_W'(1);
                end
            end
            ST_WALK:
            begin
                if (walk_ok)
                begin
                    if (walk_emit)
                    begin
                        emit          = 1'b1;
                        e_elem        = rd_data_reg;
                        e_last        = walk_last;
                        emit_cnt_next = emit_cnt_reg + CNT_W'(1);
                    end
                    case (phase_reg)
                        PH_ENTER:
                        begin
                            if (child_l <= cnt_wide)
                            begin
                                node_next = child_l[CNT_W-1:0];
                            end
                            else
                            begin
                                phase_next = PH_LEFT_DONE;
                            end
                        end
                        PH_LEFT_DONE:
                        begin
                            if (child_r <= cnt_wide)
                            begin
                                node_next  = child_r[CNT_W-1:0];
                                phase_next = PH_ENTER;
                            end
                            else
                            begin
                                phase_next = PH_RIGHT_DONE;
                            end
                        end
                        default:
                        begin
                            // climb: a right child returns into its parent's last phase
                            if (node_reg != CNT_W'(1))
                            begin
                                phase_next = node_reg[0] ? PH_RIGHT_DONE : PH_LEFT_DONE;
                                node_next  = node_reg >> 1;
                            end
                        end
                    endcase
                end
            end
            ST_REPLY:
            begin
                if (out_free)
                begin
                    emit    = 1'b1;
                    e_found = rep_found_reg;
                    e_full  = rep_full_reg;
                    e_empty = rep_empty_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_ENTER;
            op_reg        <= OP_INSERT;
            cnt_reg       <= '0;
            node_reg      <= '0;
            emit_cnt_reg  <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            op_reg       <= op_next;
            cnt_reg      <= cnt_next;
            node_reg     <= node_next;
            emit_cnt_reg <= emit_cnt_next;
            hit_reg      <= hit_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg    <= target_next;
        key_reg       <= key_next;
        rep_found_reg <= rep_found_next;
        rep_full_reg  <= rep_full_next;
        rep_empty_reg <= rep_empty_next;
        if (emit)
        begin
            out_elem_reg   <= e_elem;
            out_found_reg  <= e_found;
            out_full_reg   <= e_full;
            out_empty_reg  <= e_empty;
            out_last_reg   <= e_last;
            out_count_reg  <= cnt_reg;
            out_height_reg <= height_code(cnt_reg);
        end
    end

    // slot memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_count_reg, out_height_reg, out_empty_reg,
                       out_full_reg, out_found_reg, out_elem_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_tready)
        else $error("ready again right after an accepted beat");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (op_in == OP_INSERT) && (cnt_reg < CNT_W'(CAPACITY)))
        |=> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("insert did not grow the count");

    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && e_last) |=> (state_reg == ST_IDLE))
        else $error("sequencer still busy after the final beat");

endmodule
`default_nettype wire
